// ===== rtl/vic_pkg.sv =====
package vic_pkg;

  // Configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_I = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_J = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_K = 2'd2;

  // 3x3x3 window
  localparam int WIN_BITS   = 27;
  localparam int WIN_CENTER = 13;

  // Result labels
  typedef enum logic [1:0] {
    LABEL_FLUID    = 2'd0,
    LABEL_SURFACE  = 2'd1,
    LABEL_INTERIOR = 2'd2
  } label_t;

endpackage

// ===== rtl/vic_voxel_if.sv =====
interface vic_voxel_if;
  logic valid;
  logic ready;
  logic solid;
  logic pad;

  modport source (output valid, output solid, output pad, input ready);
  modport sink   (input valid, input solid, input pad, output ready);
endinterface

// ===== rtl/vic_label_if.sv =====
interface vic_label_if;
  logic            valid;
  logic            ready;
  vic_pkg::label_t label;
  logic            last;

  modport source (output valid, output label, output last, input ready);
  modport sink   (input valid, input label, input last, output ready);
endinterface

// ===== rtl/voxel_interior_classifier_3d.sv =====
// Streaming 3x3x3 interior classifier for a binary voxel volume sent in raster
// order (plane, line, voxel). It takes one voxel beat per cycle and gives one
// label beat per voxel: fluid, surface solid (fluid somewhere in its 26
// neighbours) or interior solid; voxels on a line or plane-row border are
// always labeled interior, and neighbours outside the volume count as solid.
// A label leaves dim_j*dim_k + dim_k + 1 advancing beats after its voxel, plus
// two register stages (window, result), so the source follows the volume with
// that many pad beats to flush it; a pad beat before the volume is complete is
// a bubble and moves nothing. The rate is one beat per cycle, set by the two
// single-port plane delay memories and two line delay memories, each read and
// written once per beat. The input is refused only while both the window stage
// and the result register hold a label that the sink has not taken. Writing any
// dimension register restarts the stream; write only while the block is idle.
module voxel_interior_classifier_3d #(
  parameter int MAX_DIM = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  vic_voxel_if.sink                        voxel,
  vic_label_if.source                      result,
  input  logic                             cfg_we,
  input  logic [vic_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [vic_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW      = vic_pkg::CFG_W;
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int LW      = $clog2(MAX_DIM);
  localparam int PW      = $clog2(MAX_DIM * MAX_DIM);
  localparam int PRW     = 2 * DW;
  localparam int RST_DIM = (256 > MAX_DIM) ? MAX_DIM : 256;

  function automatic logic [DW-1:0] clamp_dim(input logic [CW-1:0] v);
    if (v < CW'(3)) return DW'(3);
    if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  // Configuration, kept in the forms the datapath uses
  logic [DW-1:0]  dj_c, dk_c;
  logic [LW-1:0]  di_m1, dj_m1, dk_m1, dk_m2;
  logic [PW-1:0]  plane_m1, plane_m2;

  // Stream control
  logic [LW-1:0]  ii, ij, ik;
  logic [LW-1:0]  oi, oj, ok;
  logic           in_done;
  logic           primed;
  logic [PW-1:0]  p1_ptr, p2_ptr;
  logic [LW-1:0]  l_ptr;
  logic           w_valid;
  logic           out_valid;

  // Delay memories and their read registers
  logic           plane_delay_near [MAX_DIM*MAX_DIM];
  logic           plane_delay_far  [MAX_DIM*MAX_DIM];
  logic [2:0]     line_delay_near  [MAX_DIM];
  logic [2:0]     line_delay_far   [MAX_DIM];
  logic           p1_rd, p2_rd;
  logic [2:0]     l1_rd, l2_rd;

  // Window and result payload
  logic           in_reg;
  logic [8:0]     g1, g2;
  logic [2:0]     col;
  logic [8:0]     g0;
  logic [vic_pkg::WIN_BITS-1:0] win, win_m;
  logic [LW-1:0]  wi, wj, wk;
  logic           w_last;
  vic_pkg::label_t res_label, label_next;
  logic           res_last;

  // Handshake and sequencing terms
  logic           move, free, acc, adv, emit, o_last, restart, first_out;
  logic [DW-1:0]  cfg_dim;
  logic [PRW-1:0] cfg_prod;

  assign move      = w_valid && (!out_valid || result.ready);
  assign free      = !w_valid || move;
  assign acc       = voxel.valid && voxel.ready;
  assign adv       = acc && (in_done || !voxel.pad);
  assign first_out = !in_done && ii == LW'(1) && ij == LW'(1) && ik == LW'(1);
  assign emit      = primed || first_out;
  assign o_last    = oi == di_m1 && oj == dj_m1 && ok == dk_m1;
  assign restart   = cfg_we && (cfg_idx == vic_pkg::CFG_DIM_I ||
                                cfg_idx == vic_pkg::CFG_DIM_J ||
                                cfg_idx == vic_pkg::CFG_DIM_K);

  assign voxel.ready  = free;
  assign result.valid = out_valid;
  assign result.label = res_label;
  assign result.last  = res_last;

  // Clamp the written dimension and form the new plane size
  always_comb begin
    cfg_dim  = clamp_dim(cfg_data);
    cfg_prod = PRW'(cfg_dim) *
               PRW'((cfg_idx == vic_pkg::CFG_DIM_J) ? dk_c : dj_c);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dj_c      <= DW'(RST_DIM);
      dk_c      <= DW'(RST_DIM);
      di_m1     <= LW'(RST_DIM - 1);
      dj_m1     <= LW'(RST_DIM - 1);
      dk_m1     <= LW'(RST_DIM - 1);
      dk_m2     <= LW'(RST_DIM - 2);
      plane_m1  <= PW'(RST_DIM * RST_DIM - 1);
      plane_m2  <= PW'(RST_DIM * RST_DIM - 2);
      ii        <= '0;
      ij        <= '0;
      ik        <= '0;
      oi        <= '0;
      oj        <= '0;
      ok        <= '0;
      in_done   <= 1'b0;
      primed    <= 1'b0;
      p1_ptr    <= '0;
      p2_ptr    <= '0;
      l_ptr     <= '0;
      w_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Take a dimension write
      if (cfg_we) begin
        case (cfg_idx)
          vic_pkg::CFG_DIM_I: begin
            di_m1 <= LW'(cfg_dim - DW'(1));
          end
          vic_pkg::CFG_DIM_J: begin
            dj_c     <= cfg_dim;
            dj_m1    <= LW'(cfg_dim - DW'(1));
            plane_m1 <= PW'(cfg_prod - PRW'(1));
            plane_m2 <= PW'(cfg_prod - PRW'(2));
          end
          vic_pkg::CFG_DIM_K: begin
            dk_c     <= cfg_dim;
            dk_m1    <= LW'(cfg_dim - DW'(1));
            dk_m2    <= LW'(cfg_dim - DW'(2));
            plane_m1 <= PW'(cfg_prod - PRW'(1));
            plane_m2 <= PW'(cfg_prod - PRW'(2));
          end
          default: ;
        endcase
      end

      if (restart) begin
        ii      <= '0;
        ij      <= '0;
        ik      <= '0;
        oi      <= '0;
        oj      <= '0;
        ok      <= '0;
        in_done <= 1'b0;
        primed  <= 1'b0;
        p1_ptr  <= '0;
        p2_ptr  <= '0;
        l_ptr   <= '0;
      end else if (adv) begin
        // Advance the delay pointers
        p1_ptr <= (p1_ptr == plane_m1) ? '0 : p1_ptr + PW'(1);
        p2_ptr <= (p2_ptr == plane_m2) ? '0 : p2_ptr + PW'(1);
        l_ptr  <= (l_ptr == dk_m2) ? '0 : l_ptr + LW'(1);

        // Step the input position until the volume is complete
        if (!in_done) begin
          if (ik == dk_m1) begin
            ik <= '0;
            if (ij == dj_m1) begin
              ij <= '0;
              if (ii == di_m1) in_done <= 1'b1;
              else ii <= ii + LW'(1);
            end else begin
              ij <= ij + LW'(1);
            end
          end else begin
            ik <= ik + LW'(1);
          end
        end

        // Step the output position; restart after the final voxel
        if (emit) begin
          primed <= 1'b1;
          if (ok == dk_m1) begin
            ok <= '0;
            if (oj == dj_m1) begin
              oj <= '0;
              oi <= oi + LW'(1);
            end else begin
              oj <= oj + LW'(1);
            end
          end else begin
            ok <= ok + LW'(1);
          end
          if (o_last) begin
            ii      <= '0;
            ij      <= '0;
            ik      <= '0;
            oi      <= '0;
            oj      <= '0;
            ok      <= '0;
            in_done <= 1'b0;
            primed  <= 1'b0;
          end
        end
      end

      // Window stage and result register occupancy
      if (adv) w_valid <= emit;
      else if (move) w_valid <= 1'b0;

      if (move) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Plane delays: near is one plane long, far one less to absorb its input register
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rd <= plane_delay_near[p1_ptr];
      plane_delay_near[p1_ptr] <= voxel.solid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_rd <= plane_delay_far[p2_ptr];
      plane_delay_far[p2_ptr] <= p1_rd;
    end
  end

  // Line delays carry three-plane columns, one line minus one each
  always_ff @(posedge clk) begin
    if (adv) begin
      l1_rd <= line_delay_near[l_ptr];
      line_delay_near[l_ptr] <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_rd <= line_delay_far[l_ptr];
      line_delay_far[l_ptr] <= l1_rd;
    end
  end

  // Window: bit 9*voxel + 3*line + plane offset, newest at zero
  assign col = {p2_rd, p1_rd, in_reg};
  assign g0  = {l2_rd, l1_rd, col};
  assign win = {g2, g1, g0};

  // Classify the window center
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int b = 0; b < 3; b++) begin
        for (int a = 0; a < 3; a++) begin
          win_m[9*c + 3*b + a] = win[9*c + 3*b + a] ||
                                 (a == 2 && wi == '0) ||
                                 (a == 0 && wi == di_m1);
        end
      end
    end
    if (wj == '0 || wk == '0 || wj == dj_m1 || wk == dk_m1) begin
      label_next = vic_pkg::LABEL_INTERIOR;
    end else if (!win[vic_pkg::WIN_CENTER]) begin
      label_next = vic_pkg::LABEL_FLUID;
    end else if (!(&win_m)) begin
      label_next = vic_pkg::LABEL_SURFACE;
    end else begin
      label_next = vic_pkg::LABEL_INTERIOR;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      in_reg <= voxel.solid;
      g1     <= g0;
      g2     <= g1;
      if (emit) begin
        wi     <= oi;
        wj     <= oj;
        wk     <= ok;
        w_last <= o_last;
      end
    end
    if (move) begin
      res_label <= label_next;
      res_last  <= w_last;
    end
  end

  // Checks
  a_emit_loads_window: assert property (@(posedge clk) disable iff (rst)
    adv && emit |=> w_valid)
    else $error("emitting beat did not load the window stage");

  a_window_holds: assert property (@(posedge clk) disable iff (rst)
    w_valid && !move |=> $stable({wi, wj, wk, g1, g2, in_reg}))
    else $error("window changed while its label was waiting");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    p1_ptr <= plane_m1 && p2_ptr <= plane_m2 && l_ptr <= dk_m2)
    else $error("delay pointer beyond its length");

  a_volume_restart: assert property (@(posedge clk) disable iff (rst)
    adv && emit && o_last |=> !primed && !in_done && ok == '0 && ik == '0)
    else $error("stream did not restart after the final voxel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !voxel.ready |-> w_valid && out_valid && !result.ready)
    else $error("input refused with a free stage");

endmodule
